>>> src/vehicle_arc_pose_integrator_assert.svh
// Assertion macros for the vehicle arc pose integrator.
`ifndef VEHICLE_ARC_POSE_INTEGRATOR_ASSERT_SVH
`define VEHICLE_ARC_POSE_INTEGRATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define VAPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VAPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/vapi_pkg.sv
// Package with shared constants, command codes and the arctangent table.
package vapi_pkg;
  localparam int CordicSteps = 24;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;
  localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
  localparam logic [15:0] MinTurnRadiusReset = 16'd914;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_STEER = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction
endpackage

>>> src/vehicle_arc_pose_integrator.sv
// Pose integrator: sequencer around one shared divider, CORDIC stage and multiplier.
// Work per item, up to the result handshake: an arc move does two CORDIC runs of CordicSteps,
// a 64-step divide and the multiply steps; a straight move does one CORDIC run and the multiply
// steps; a nonzero steer does a 64-step divide; load, unused code and zero steer answer from idle.
// One item at a time: s_tready is low while an item is in work or its result waits.
// Synchronous reset clears pose, steer, radius.
module vehicle_arc_pose_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // lsb up: command[1:0], steer_value[17:2], speed[33:18], time_step[49:34],
  // load_x[81:50], load_y[113:82], load_heading[145:114], zero fill to 152
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // lsb up: pos_x[31:0], pos_y[63:32], heading[95:64], steer_now[111:96],
  // radius_now[143:112]
  output logic [143:0] m_tdata
);
  import vapi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVEND, S_TURN, S_COR, S_CORDONE, S_MUL0, S_MUL1, S_POS, S_OUT
  } state_t;

  state_t state;
  logic [15:0] min_turn_radius;
  logic signed [31:0] x_position, y_position, r_reg;
  logic [31:0] heading_angle;
  logic signed [15:0] steer_amount;

  logic mode_steer, arc, second;
  logic signed [31:0] travel;
  // shared restoring divider
  logic [63:0] quo;
  logic [64:0] rem;
  logic [31:0] dvs;
  logic neg_q;
  logic [6:0] dcnt;
  // shared CORDIC
  logic signed [33:0] cx, cy;
  logic signed [33:0] cz;
  logic flip;
  logic [StepW-1:0] ci;
  logic signed [33:0] c0, s0, c1, s1;
  // shared multiplier
  logic signed [63:0] prod;
  logic [1:0] mstep;
  logic signed [63:0] acc_a;

  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  always_comb begin
    rem_sh = {rem[63:0], quo[63]};
    rem_sub = rem_sh - {33'd0, dvs};
  end

  logic signed [33:0] xs, ys, atv;
  always_comb begin
    xs = cx >>> ci;
    ys = cy >>> ci;
    atv = $signed({2'b00, atan_bam(5'(ci))});
  end

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  always_comb begin
    mul_a = '0; mul_b = '0;
    unique case (mstep)
      2'd0: begin mul_a = arc ? (s1 - s0) : c0; mul_b = arc ? r_reg : travel; end
      2'd1: begin mul_a = arc ? (c0 - c1) : s0; mul_b = arc ? r_reg : travel; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [63:0] mag;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata = {r_reg, steer_amount, heading_angle, y_position, x_position};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_tvalid <= 1'b0; min_turn_radius <= MinTurnRadiusReset;
      x_position <= '0; y_position <= '0; heading_angle <= '0;
      steer_amount <= '0; r_reg <= '0;
    end else begin
      if (cfg_we) min_turn_radius <= cfg_wdata;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          travel <= 32'($signed(s_tdata[33:18]) * $signed({1'b0, s_tdata[49:34]}));
          second <= 1'b0;
          unique case (cmd_t'(s_tdata[1:0]))
            CMD_STEER: begin
              logic signed [15:0] sv;
              sv = $signed(s_tdata[17:2]);
              if (sv > 16'sd16384) sv = 16'sd16384;
              if (sv < -16'sd16384) sv = -16'sd16384;
              steer_amount <= sv;
              mode_steer <= 1'b1;
              if (sv == 0) begin
                r_reg <= '0; m_tvalid <= 1'b1;
              end else begin
                quo <= {26'd0, min_turn_radius, 22'd0};
                dvs <= 32'(sv < 0 ? -sv : sv);
                neg_q <= sv < 0; rem <= '0; dcnt <= '0; state <= S_DIV;
              end
            end
            CMD_MOVE: begin
              logic signed [33:0] z;
              mode_steer <= 1'b0;
              arc <= (steer_amount != 0) && (r_reg != 0);
              cx <= 34'(CordicGainQ30); cy <= '0; ci <= '0;
              state <= S_COR;
              z = $signed({{2{heading_angle[31]}}, heading_angle});
              if (z > 34'sd1073741824) begin
                cz <= z - 34'sd2147483648; flip <= 1'b1;
              end else if (z < -34'sd1073741824) begin
                cz <= z + 34'sd2147483648; flip <= 1'b1;
              end else begin
                cz <= z; flip <= 1'b0;
              end
            end
            CMD_LOAD: begin
              x_position <= $signed(s_tdata[81:50]);
              y_position <= $signed(s_tdata[113:82]);
              heading_angle <= s_tdata[145:114];
              m_tvalid <= 1'b1;
            end
            default: m_tvalid <= 1'b1;
          endcase
        end
        S_DIV: begin
          if (!rem_sub[64]) begin
            rem <= rem_sub; quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh; quo <= {quo[62:0], 1'b0};
          end
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd63) state <= S_DIVEND;
        end
        S_DIVEND: begin
          if (mode_steer) begin
            r_reg <= sat32(neg_q ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));
            m_tvalid <= 1'b1; state <= S_IDLE;
          end else begin
            mag <= quo; state <= S_TURN;
          end
        end
        S_TURN: begin
          logic [63:0] tlo, thi;
          logic [31:0] turn, h;
          logic signed [33:0] z;
          tlo = 64'(mag[31:0]) * 64'(InvTwoPiQ32);
          thi = 64'(mag[63:32]) * 64'(InvTwoPiQ32);
          turn = thi[31:0] + tlo[63:32];
          if (neg_q) turn = 32'd0 - turn;
          heading_angle <= heading_angle + turn;
          h = heading_angle + turn;
          z = $signed({{2{h[31]}}, h});
          if (z > 34'sd1073741824) begin
            cz <= z - 34'sd2147483648; flip <= 1'b1;
          end else if (z < -34'sd1073741824) begin
            cz <= z + 34'sd2147483648; flip <= 1'b1;
          end else begin
            cz <= z; flip <= 1'b0;
          end
          cx <= 34'(CordicGainQ30); cy <= '0; ci <= '0; second <= 1'b1;
          state <= S_COR;
        end
        S_COR: begin
          if (cz >= 0) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - atv;
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + atv;
          end
          ci <= ci + 1'b1;
          if (ci == StepW'(CordicSteps - 1)) state <= S_CORDONE;
        end
        S_CORDONE: begin
          if (!second) begin
            c0 <= flip ? -cx : cx; s0 <= flip ? -cy : cy;
            if (arc) begin
              // numerator D * 2^24 as magnitude, sign folded in later
              quo <= 64'(travel < 0 ? -travel : travel) << 24;
              dvs <= 32'(r_reg < 0 ? -r_reg : r_reg);
              neg_q <= (travel < 0) != (r_reg < 0);
              rem <= '0; dcnt <= '0; state <= S_DIV;
            end else begin
              mstep <= 2'd0; state <= S_MUL0;
            end
          end else begin
            c1 <= flip ? -cx : cx; s1 <= flip ? -cy : cy;
            mstep <= 2'd0; state <= S_MUL0;
          end
        end
        S_MUL0: begin
          prod <= 64'(mul_a * mul_b); mstep <= 2'd1; state <= S_MUL1;
        end
        S_MUL1: begin
          acc_a <= prod; prod <= 64'(mul_a * mul_b); state <= S_POS;
        end
        S_POS: begin
          if (arc) begin
            x_position <= sat32(66'(x_position) + 66'(acc_a >>> 30));
            y_position <= sat32(66'(y_position) + 66'(prod >>> 30));
          end else begin
            x_position <= sat32(66'(x_position) + 66'(acc_a >>> 38));
            y_position <= sat32(66'(y_position) + 66'(prod >>> 38));
          end
          state <= S_OUT;
        end
        S_OUT: begin
          m_tvalid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "vehicle_arc_pose_integrator_assert.svh"
  `VAPI_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !s_tready)
  `VAPI_ASSERT_IMP(a_steer_range, 1'b1, steer_amount <= 16'sd16384 && steer_amount >= -16'sd16384)
  `VAPI_ASSERT_IMP(a_zero_steer_radius, state == S_IDLE && steer_amount == 0, r_reg == 0)
  `VAPI_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready)
endmodule

>>> sim/vehicle_arc_pose_integrator_tb.sv
// Self-checking testbench for the vehicle arc pose integrator stream block.
module vehicle_arc_pose_integrator_tb;
  import vapi_pkg::*;

  localparam int StallLimit = 6000;
  localparam int SettleCycles = 250;
  localparam bit [63:0] InvTwoPi = 64'd683565276;
  localparam longint GainQ30 = 64'sd652032874;
  localparam bit [31:0] ArcTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [151:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;

  // tracked pose and setup
  int        pose_x, pose_y, turn_r;
  bit [31:0] pose_h;
  int        steer_q;
  bit [15:0] min_radius;

  logic [143:0] pose_q[$];
  int  errors;
  int  items_sent, results_seen, cfg_writes;
  bit  jitter;
  bit  hold_req;
  int  hold_cnt;
  int  quiet_cycles;

  vehicle_arc_pose_integrator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic void rotate_unit(input bit [31:0] a, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'($signed(a));
    flip = 0;
    x = GainQ30;
    y = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31; flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31; flip = 1;
    end
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ArcTab[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ArcTab[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic void advance_pose(logic signed [15:0] spd, logic [15:0] ts);
    longint d, c0, s0, c1, s1, r, t;
    bit [63:0] mag, turn;
    d = longint'(spd) * longint'(ts);
    rotate_unit(pose_h, c0, s0);
    if (steer_q == 0 || turn_r == 0) begin
      pose_x = clip32(longint'(pose_x) + ((d * c0) >>> 38));
      pose_y = clip32(longint'(pose_y) + ((d * s0) >>> 38));
    end else begin
      r = longint'(turn_r);
      t = (d * (64'sd1 <<< 24)) / r;
      mag = (t < 0) ? 64'(-t) : 64'(t);
      turn = (mag >> 32) * InvTwoPi + (((mag & 64'hFFFFFFFF) * InvTwoPi) >> 32);
      turn &= 64'hFFFFFFFF;
      if (t < 0) turn = (64'd0 - turn) & 64'hFFFFFFFF;
      pose_h = pose_h + turn[31:0];
      rotate_unit(pose_h, c1, s1);
      pose_x = clip32(longint'(pose_x) + ((r * (s1 - s0)) >>> 30));
      pose_y = clip32(longint'(pose_y) + ((r * (c0 - c1)) >>> 30));
    end
  endfunction

  function automatic logic [143:0] next_pose(cmd_t c, logic signed [15:0] sv,
                                             logic signed [15:0] spd, logic [15:0] ts,
                                             logic [31:0] lx, ly, lh);
    longint sl;
    case (c)
      CMD_STEER: begin
        sl = longint'(sv);
        if (sl > 16384) sl = 16384;
        if (sl < -16384) sl = -16384;
        steer_q = int'(sl);
        turn_r = (sl == 0) ? 0 : clip32((longint'(min_radius) <<< 22) / sl);
      end
      CMD_MOVE: advance_pose(spd, ts);
      CMD_LOAD: begin
        pose_x = lx; pose_y = ly; pose_h = lh;
      end
      default: ;
    endcase
    return {turn_r[31:0], steer_q[15:0], pose_h, pose_y[31:0], pose_x[31:0]};
  endfunction

  task automatic send_item(cmd_t c, logic [15:0] sv, logic [15:0] spd, logic [15:0] ts,
                           logic [31:0] lx = 0, logic [31:0] ly = 0, logic [31:0] lh = 0);
    s_tdata <= {6'b0, lh, ly, lx, ts, spd, sv, c};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pose_q.insert(pose_q.size(), next_pose(c, sv, spd, ts, lx, ly, lh));
    items_sent++;
    // drop valid after each item; the block stops taking items once it accepts one anyway
    s_tvalid <= 1'b0;
    @(posedge clk);
    if (jitter && $urandom_range(99) < 15) repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic write_min_radius(logic [15:0] v);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_radius = v;
    cfg_writes++;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result side: check and apply backpressure
  always @(posedge clk) begin
    logic [143:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
        end else begin
          want = pose_q.pop_front();
          compare_field("pos_x", want[31:0], m_tdata[31:0]);
          compare_field("pos_y", want[63:32], m_tdata[63:32]);
          compare_field("heading", want[95:64], m_tdata[95:64]);
          compare_field("steer_now", {16'b0, want[111:96]}, {16'b0, m_tdata[111:96]});
          compare_field("radius_now", want[143:112], m_tdata[143:112]);
        end
      end
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !jitter || ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t timeout: no item moved for %0d cycles", $time, quiet_cycles);
      $display("FAIL vehicle_arc_pose_integrator");
      $finish;
    end
  end

  task automatic test_reset_pose();
    send_item(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, '1);
    send_item(CMD_MOVE, 16'h0000, 16'h0100, 16'h8000);
  endtask

  task automatic test_straight_extremes();
    send_item(CMD_LOAD, 0, 0, 0, 32'h0, 32'h0, 32'h2000_0000);
    send_item(CMD_MOVE, 0, 16'h7FFF, 16'hFFFF);
    send_item(CMD_MOVE, 0, 16'h8000, 16'hFFFF);
    send_item(CMD_MOVE, 0, 16'h7FFF, 16'h0000);
    send_item(CMD_LOAD, 0, 0, 0, 32'h7FFF_FFF0, 32'h8000_0010, 32'hE000_0000);
    send_item(CMD_MOVE, 0, 16'h7FFF, 16'hFFFF);
    send_item(CMD_LOAD, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_MOVE, 0, 16'h7FFF, 16'hFFFF);
  endtask

  task automatic test_steer_clamp();
    send_item(CMD_STEER, 16'h7FFF, 16'h1234, 16'h5678);
    send_item(CMD_STEER, 16'h8000, 0, 0);
    send_item(CMD_STEER, 16'h0001, 0, 0);
    send_item(CMD_STEER, 16'hFFFF, 0, 0);
    send_item(CMD_STEER, 16'h0000, 0, 0);
  endtask

  task automatic test_arc_moves();
    send_item(CMD_LOAD, 0, 0, 0, 32'h0, 32'h0, 32'h0);
    send_item(CMD_STEER, 16'd16384, 0, 0);
    send_item(CMD_MOVE, 0, 16'h0A00, 16'hFFFF);
    send_item(CMD_MOVE, 0, 16'h8000, 16'hFFFF);
    send_item(CMD_STEER, -16'sd8192, 0, 0);
    send_item(CMD_MOVE, 0, 16'h7FFF, 16'hFFFF);
    // load keeps steer and radius
    send_item(CMD_LOAD, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h4000_0000);
  endtask

  task automatic test_register_effects();
    write_min_radius(16'hFFFF);
    // radius holds until the next steer item
    send_item(CMD_MOVE, 0, 16'h0300, 16'h4000);
    send_item(CMD_STEER, 16'd1, 0, 0);
    send_item(CMD_MOVE, 0, 16'h7FFF, 16'hFFFF);
    write_min_radius(16'd1);
    send_item(CMD_STEER, 16'd16384, 0, 0);
    send_item(CMD_MOVE, 0, 16'h7FFF, 16'hFFFF);
    write_min_radius(16'd0);
    send_item(CMD_STEER, 16'd5000, 0, 0);
    send_item(CMD_MOVE, 0, 16'h0200, 16'h8000);
  endtask

  task automatic test_pressure();
    hold_req = 1;
    repeat (6) send_item(CMD_MOVE, 0, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_phase(int n, logic [15:0] radius, bit with_jitter);
    int pick;
    logic [15:0] sv, spd, ts;
    write_min_radius(radius);
    jitter = with_jitter;
    send_item(CMD_STEER, 16'($urandom_range(32768)) - 16'd16384, 0, 0);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      sv = (pick % 3 == 0) ? 16'($urandom) : 16'($urandom_range(32768)) - 16'd16384;
      if (pick % 7 == 0) sv = 0;
      spd = (pick % 2 == 0) ? 16'($urandom) : 16'($urandom_range(1024)) - 16'd512;
      ts = 16'($urandom);
      if (pick < 18) send_item(CMD_STEER, sv, 16'($urandom), ts);
      else if (pick < 84) send_item(CMD_MOVE, 16'($urandom), spd, ts);
      else if (pick < 95) send_item(CMD_LOAD, 16'($urandom), spd, ts,
                                    $urandom, $urandom, $urandom);
      else send_item(CMD_NONE, sv, spd, ts, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_tvalid = 0;
    s_tdata = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    jitter = 1;
    hold_req = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    pose_x = 0; pose_y = 0; pose_h = 0; steer_q = 0; turn_r = 0;
    min_radius = 16'd914;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_pose();
    test_straight_extremes();
    test_steer_clamp();
    test_arc_moves();
    test_register_effects();
    test_pressure();
    random_phase(380, 16'd914, 1);
    random_phase(380, 16'($urandom_range(65535, 1)), 0);
    random_phase(380, 16'hFFFF, 1);
    random_phase(380, 16'd1, 1);
    random_phase(360, 16'($urandom_range(4000, 2)), 1);

    while (pose_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d items, %0d results, %0d register writes", items_sent,
             results_seen, cfg_writes);
    $display("straight and arc moves, steer clamping, loads, unused code, long output stall");
    if (errors == 0) begin
      $display("PASS vehicle_arc_pose_integrator");
    end else begin
      $display("FAIL vehicle_arc_pose_integrator");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/vapi_pkg.sv
src/vehicle_arc_pose_integrator.sv
sim/vehicle_arc_pose_integrator_tb.sv
